[rtl/core/cqr_pkg.sv]
// ----------------------------------------------------------------------------
// cqr_pkg: shared types and constants for the circular queue with reverse
// Opcodes, result status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package cqr_pkg;

   localparam int CQR_SLOTS     = 16;
   localparam int CQR_WORD_BITS = 32;

   localparam int OPCODE_BITS = 2;
   localparam int PUSH_BITS   = 32;
   localparam int POP_BITS    = 32;
   localparam int STATUS_BITS = 2;
   localparam int OCC_BITS    = 4;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_REVERSE = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_READ,
      S_POP_STORE,
      S_PUSH_READ,
      S_PUSH_WRITE,
      S_FINISH
   } state_type;

endpackage : cqr_pkg

`default_nettype wire

[rtl/core/cqr_if.sv]
// ----------------------------------------------------------------------------
// cqr_if: request and response channels of the circular queue
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface cqr_req_if
   import cqr_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic signed [PUSH_BITS-1:0] push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface : cqr_req_if

interface cqr_rsp_if
   import cqr_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic signed [POP_BITS-1:0] pop_value;
   logic [STATUS_BITS-1:0] status;
   logic [OCC_BITS-1:0]    occupancy;

   modport source (output valid, output pop_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input pop_value, input status, input occupancy,
                   output ready);
endinterface : cqr_rsp_if

`default_nettype wire

[rtl/core/cqr_ram.sv]
// ----------------------------------------------------------------------------
// cqr_ram: simple dual-port word memory
// One write port and one read port with registered, enable-held read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cqr_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold the last word read while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : cqr_ram

`default_nettype wire

[rtl/core/circular_queue_with_reverse.sv]
// ----------------------------------------------------------------------------
// circular_queue_with_reverse: ring FIFO of signed words with order reversal
// Enqueue, dequeue and reverse on a SLOTS-slot ring that holds SLOTS-1 words.
// ----------------------------------------------------------------------------
// One request beat gives one response beat with the dequeued word, a status
// and the occupancy after the operation. The block takes one request at a
// time: req ready is high only while the sequencer is idle, and a finished
// response may wait in the output register while the next request is taken.
// Enqueue, dequeue and no-op go straight from idle to the finish state.
// Reverse moves the N stored words: each word is read from the
// queue memory and written to the stack memory, then read back from the
// stack and written to the queue, each memory read having a state of its
// own. Memory contents are not cleared at reset; only occupied slots are read.
`default_nettype none

module circular_queue_with_reverse
   import cqr_pkg::*;
#(
   parameter int SLOTS     = CQR_SLOTS,
   parameter int WORD_BITS = CQR_WORD_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   cqr_req_if.sink   req_ch,
   cqr_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = IDX_W + 1;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic [IDX_W-1:0]       sp_ff, sp_in;
   status_type             status_ff, status_in;
   logic                   deq_ok_ff, deq_ok_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [POP_BITS-1:0]    rsp_pop_ff, rsp_pop_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [OCC_BITS-1:0]    rsp_occ_ff, rsp_occ_in;

   logic                   q_we, q_re, s_we, s_re;
   logic [IDX_W-1:0]       q_waddr, q_raddr, s_waddr, s_raddr;
   logic [WORD_BITS-1:0]   q_wdata, q_rdata, s_rdata;

   logic [WORD_BITS-1:0]   push_word;
   logic [POP_BITS-1:0]    pop_word;
   logic [CNT_W-1:0]       occ_cnt;
   logic [OCC_BITS-1:0]    occ_out;
   logic [IDX_W-1:0]       head_next, tail_next;
   logic                   req_fire, out_free;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      if (idx == IDX_W'(SLOTS - 1)) begin
         return '0;
      end
      return idx + IDX_W'(1);
   endfunction

   // word width adaptation between the ports and the stored words
   if (WORD_BITS > PUSH_BITS) begin : g_push_wide
      assign push_word = {{(WORD_BITS - PUSH_BITS){1'b0}}, req_ch.push_value};
   end else begin : g_push_narrow
      assign push_word = req_ch.push_value[WORD_BITS-1:0];
   end

   if (WORD_BITS >= POP_BITS) begin : g_pop_wide
      assign pop_word = q_rdata[POP_BITS-1:0];
   end else begin : g_pop_narrow
      assign pop_word = {{(POP_BITS - WORD_BITS){q_rdata[WORD_BITS-1]}}, q_rdata};
   end

   assign occ_cnt = (tail_ff >= head_ff)
                  ? CNT_W'(tail_ff) - CNT_W'(head_ff)
                  : CNT_W'(tail_ff) + CNT_W'(SLOTS) - CNT_W'(head_ff);

   if (CNT_W >= OCC_BITS) begin : g_occ_trunc
      assign occ_out = occ_cnt[OCC_BITS-1:0];
   end else begin : g_occ_ext
      assign occ_out = {{(OCC_BITS - CNT_W){1'b0}}, occ_cnt};
   end

   assign head_next = next_idx(head_ff);
   assign tail_next = next_idx(tail_ff);
   assign req_fire  = req_ch.valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   cqr_ram #(.DEPTH(SLOTS), .WIDTH(WORD_BITS)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   cqr_ram #(.DEPTH(SLOTS), .WIDTH(WORD_BITS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (q_rdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      sp_in     = sp_ff;
      status_in = status_ff;
      deq_ok_in = deq_ok_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_pop_in    = rsp_pop_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;

      q_we    = 1'b0;
      q_waddr = tail_next;
      q_wdata = push_word;
      q_re    = 1'b0;
      q_raddr = head_next;
      s_we    = 1'b0;
      s_re    = 1'b0;
      s_raddr = sp_ff - IDX_W'(1);
      s_waddr = sp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               status_in = ST_OK;
               deq_ok_in = 1'b0;
               state_in  = S_FINISH;
               unique case (req_ch.opcode)
                  OP_ENQUEUE: begin
                     if (tail_next == head_ff) begin
                        status_in = ST_FULL;
                     end else begin
                        q_we    = 1'b1;
                        tail_in = tail_next;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (head_ff == tail_ff) begin
                        status_in = ST_EMPTY;
                     end else begin
                        q_re      = 1'b1;
                        head_in   = head_next;
                        deq_ok_in = 1'b1;
                     end
                  end
                  OP_REVERSE: begin
                     sp_in = '0;
                     if (head_ff != tail_ff) begin
                        state_in = S_POP_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP_READ: begin
            q_re     = 1'b1;
            head_in  = head_next;
            state_in = S_POP_STORE;
         end
         S_POP_STORE: begin
            // push the drained word, then refill once the queue runs dry
            s_we     = 1'b1;
            sp_in    = sp_ff + IDX_W'(1);
            state_in = (head_ff == tail_ff) ? S_PUSH_READ : S_POP_READ;
         end
         S_PUSH_READ: begin
            s_re     = 1'b1;
            sp_in    = sp_ff - IDX_W'(1);
            state_in = S_PUSH_WRITE;
         end
         S_PUSH_WRITE: begin
            q_we     = 1'b1;
            q_wdata  = s_rdata;
            tail_in  = tail_next;
            state_in = (sp_ff == '0) ? S_FINISH : S_PUSH_READ;
         end
         S_FINISH: begin
            // hold until the output register can take the beat
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pop_in    = deq_ok_ff ? pop_word : '0;
               rsp_status_in = status_ff;
               rsp_occ_in    = occ_out;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= IDX_W'(SLOTS - 1);
         tail_ff      <= IDX_W'(SLOTS - 1);
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      deq_ok_ff     <= deq_ok_in;
      rsp_pop_ff    <= rsp_pop_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.pop_value = rsp_pop_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.occupancy = rsp_occ_ff;

endmodule : circular_queue_with_reverse

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for circular_queue_with_reverse
// Walks a short list of directed operations (empty/full queue, extreme words,
// reverse on zero, one, four and fifteen entries, unused opcode), then about 1100
// random operations in four flow-control phases. Every response beat is
// checked against its table entry or a queue-level model kept alongside the DUT.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
   import cqr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OPCODE_BITS-1:0] OP_NOP = 2'd3;
   localparam int CAPACITY     = CQR_SLOTS - 1;
   localparam int RANDOM_ITEMS = 1100;
   localparam int PHASES       = 4;
   localparam int DRAIN_CYCLES = 4 * CQR_SLOTS + 40;
   localparam int N_ROWS       = 19;

   typedef struct packed {
      logic signed [POP_BITS-1:0] pop_value;
      logic [STATUS_BITS-1:0]     status;
      logic [OCC_BITS-1:0]        occupancy;
   } rsp_beat_type;

   typedef struct {
      logic [OPCODE_BITS-1:0]      opcode;
      logic signed [PUSH_BITS-1:0] push_value;
      int                          reps;
      bit                          typed;
      rsp_beat_type                want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cqr_req_if req_ch ();
   cqr_rsp_if rsp_ch ();

   circular_queue_with_reverse i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // queue contents as the DUT should hold them, oldest first
   logic signed [PUSH_BITS-1:0] model_words[$];
   rsp_beat_type                pending_rsp[$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int n_errors      = 0;
   int n_checked     = 0;
   int n_enq_ok      = 0;
   int n_full        = 0;
   int n_deq_ok      = 0;
   int n_deq_empty   = 0;
   int n_reverse     = 0;
   int n_nop         = 0;

   function automatic rsp_beat_type predict_queue_op(
      input logic [OPCODE_BITS-1:0]      opcode,
      input logic signed [PUSH_BITS-1:0] value);
      rsp_beat_type                beat;
      logic signed [PUSH_BITS-1:0] flipped[$];
      beat = '0;
      case (opcode)
         OP_ENQUEUE: begin
            if (model_words.size() < CAPACITY) begin
               model_words.push_back(value);
               n_enq_ok++;
            end else begin
               beat.status = ST_FULL;
               n_full++;
            end
         end
         OP_DEQUEUE: begin
            if (model_words.size() != 0) begin
               beat.pop_value = model_words.pop_front();
               n_deq_ok++;
            end else begin
               beat.status = ST_EMPTY;
               n_deq_empty++;
            end
         end
         OP_REVERSE: begin
            for (int i = 0; i < model_words.size(); i++)
               flipped.push_front(model_words[i]);
            model_words = flipped;
            n_reverse++;
         end
         default: begin
            n_nop++;
         end
      endcase
      beat.occupancy = OCC_BITS'(model_words.size());
      return beat;
   endfunction

   // Drive one request beat from a falling edge; return at the falling edge after acceptance.
   task automatic send_beat(input logic [OPCODE_BITS-1:0] opcode,
                            input logic signed [PUSH_BITS-1:0] value,
                            input bit typed, input rsp_beat_type want);
      rsp_beat_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= opcode;
      req_ch.push_value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = predict_queue_op(opcode, value);
      pending_rsp.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t ns: %s expected %0h, got %0h", $realtime, field, want, got);
      n_errors++;
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, got pop %0h status %0d occ %0d",
                     $realtime, rsp_ch.pop_value, rsp_ch.status, rsp_ch.occupancy);
            n_errors++;
         end else begin
            want = pending_rsp.pop_front();
            n_checked++;
            if (rsp_ch.pop_value !== want.pop_value)
               report_field("pop_value", want.pop_value, rsp_ch.pop_value);
            if (rsp_ch.status !== want.status)
               report_field("status", 32'(want.status), 32'(rsp_ch.status));
            if (rsp_ch.occupancy !== want.occupancy)
               report_field("occupancy", 32'(want.occupancy), 32'(rsp_ch.occupancy));
         end
      end
   end

   // response sink with random back-pressure
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      stim_row_type                directed_rows[N_ROWS];
      logic [OPCODE_BITS-1:0]      opcode;
      logic signed [PUSH_BITS-1:0] value;
      int                          fill_mode;
      int                          enq_pct;
      int                          pick;

      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_ENQUEUE;
      req_ch.push_value = '0;

      directed_rows = '{
         '{OP_DEQUEUE, 32'sh0,        1,  1'b1, '{32'sh0, ST_EMPTY, 4'd0}},
         '{OP_REVERSE, 32'sh0,        1,  1'b1, '{32'sh0, ST_OK,    4'd0}},
         '{OP_NOP,     32'sh0,        1,  1'b1, '{32'sh0, ST_OK,    4'd0}},
         '{OP_ENQUEUE, 32'sh7fffffff, 1,  1'b1, '{32'sh0, ST_OK,    4'd1}},
         '{OP_REVERSE, 32'shffffffff, 1,  1'b1, '{32'sh0, ST_OK,    4'd1}},
         '{OP_DEQUEUE, 32'sh0,        1,  1'b1, '{32'sh7fffffff, ST_OK, 4'd0}},
         '{OP_ENQUEUE, 32'sh80000000, 1,  1'b1, '{32'sh0, ST_OK,    4'd1}},
         '{OP_ENQUEUE, 32'shffffffff, 1,  1'b1, '{32'sh0, ST_OK,    4'd2}},
         '{OP_ENQUEUE, 32'sh0,        1,  1'b1, '{32'sh0, ST_OK,    4'd3}},
         '{OP_ENQUEUE, 32'sh1,        1,  1'b0, '{32'sh0, ST_OK,    4'd0}},
         '{OP_REVERSE, 32'sh55555555, 1,  1'b0, '{32'sh0, ST_OK,    4'd0}},
         '{OP_DEQUEUE, 32'shaaaaaaaa, 1,  1'b0, '{32'sh0, ST_OK,    4'd0}},
         '{OP_DEQUEUE, 32'sh0,        1,  1'b0, '{32'sh0, ST_OK,    4'd0}},
         '{OP_ENQUEUE, 32'sh5a5a5a5a, 13, 1'b0, '{32'sh0, ST_OK,    4'd0}},
         '{OP_ENQUEUE, 32'sh12345678, 1,  1'b1, '{32'sh0, ST_FULL,  4'd15}},
         '{OP_REVERSE, 32'sh0,        1,  1'b0, '{32'sh0, ST_OK,    4'd0}},
         '{OP_NOP,     32'shdeadbeef, 1,  1'b0, '{32'sh0, ST_OK,    4'd0}},
         '{OP_DEQUEUE, 32'sh0,        15, 1'b0, '{32'sh0, ST_OK,    4'd0}},
         '{OP_DEQUEUE, 32'sh0,        1,  1'b1, '{32'sh0, ST_EMPTY, 4'd0}}
      };

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r])
         for (int k = 0; k < directed_rows[r].reps; k++)
            send_beat(directed_rows[r].opcode, directed_rows[r].push_value + k,
                      directed_rows[r].typed, directed_rows[r].want);

      fill_mode = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 79; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         // hold requests until the DUT has answered everything
         if (phase != 0) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
            while (pending_rsp.size() != 0) @(negedge clock);
         end
         for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
            // alternate between filling, draining and balanced stretches
            if (k % 40 == 0) fill_mode = $urandom_range(0, 2);
            enq_pct = (fill_mode == 0) ? 70 : (fill_mode == 1) ? 15 : 42;
            pick = $urandom_range(0, 99);
            if (pick < 3)
               opcode = OP_NOP;
            else if (pick < 12)
               opcode = OP_REVERSE;
            else if (pick < 12 + enq_pct)
               opcode = OP_ENQUEUE;
            else
               opcode = OP_DEQUEUE;
            if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 3))
                  0: value = 32'sh0;
                  1: value = 32'shffffffff;
                  2: value = 32'sh80000000;
                  default: value = 32'sh7fffffff;
               endcase
            end else begin
               value = $urandom;
            end
            send_beat(opcode, value, 1'b0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d responses: %0d words stored, %0d rejected on full, %0d dequeued,",
               n_checked, n_enq_ok, n_full, n_deq_ok);
      $display("%0d dequeues on empty, %0d reverses, %0d unused-opcode beats.",
               n_deq_empty, n_reverse, n_nop);
      if (n_errors == 0)
         $display("circular_queue_with_reverse: match");
      else
         $display("circular_queue_with_reverse: mismatch");
      $finish;
   end

   initial begin
      #10ms;
      $display("Timed out with %0d responses outstanding", pending_rsp.size());
      $display("circular_queue_with_reverse: mismatch");
      $finish;
   end

endmodule : tb

`default_nettype wire

[filelist.f]
rtl/core/cqr_pkg.sv
rtl/core/cqr_if.sv
rtl/core/cqr_ram.sv
rtl/core/circular_queue_with_reverse.sv
test/tb.sv
